[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

[src/w816dec_pkg.sv]
// ----------------------------------------------------------------------------
// w816dec_pkg
// Types, opcode table and constants for the 65816 instruction decoder.
// ----------------------------------------------------------------------------
package w816dec_pkg;

	// Mnemonics in alphabetical order
	typedef enum logic [6:0] {
		ADC, AND, ASL, BCC, BCS, BEQ, BIT, BMI, BNE, BPL, BRA, BRK, BRL, BVC, BVS,
		CLC, CLD, CLI, CLV, CMP, COP, CPX, CPY, DEC, DEX, DEY, EOR, INC, INX, INY,
		JML, JMP, JSL, JSR, LDA, LDX, LDY, LSR, MVN, MVP, NOP, ORA, PEA, PEI, PER,
		PHA, PHB, PHD, PHK, PHP, PHX, PHY, PLA, PLB, PLD, PLP, PLX, PLY, REP, ROL,
		ROR, RTI, RTL, RTS, SBC, SEC, SED, SEI, SEP, STA, STP, STX, STY, STZ, TAX,
		TAY, TCD, TCS, TDC, TRB, TSB, TSC, TSX, TXA, TXS, TXY, TYA, TYX, WAI, WDM,
		XBA, XCE
	} mnem_t;

	// Addressing modes
	typedef enum logic [4:0] {
		IMP, MOV, SR, SRY, DIX, DP, IMM, ABS, ABL, REL, RLL, DIN, DIY, DIL, DLY,
		DPX, ABY, ABX, ALX, AIX, AIN, AIL, DPY
	} amode_t;

	typedef struct packed {
		mnem_t  mn;
		amode_t md;
	} op_entry_t;

	// Decoded word handed to the output register
	typedef struct packed {
		mnem_t       mn;
		amode_t      md;
		logic [2:0]  len;
		logic [23:0] value;
		logic        ends;
	} dec_result_t;

	// Status masks: M or E, X or E
	localparam logic [8:0]  ST_M_E_MASK = 9'h120;
	localparam logic [8:0]  ST_X_E_MASK = 9'h110;
	localparam logic [15:0] REL_BIAS    = 16'd2;
	localparam logic [15:0] RLL_BIAS    = 16'd3;

	localparam op_entry_t OPTAB [256] = '{
		'{BRK,IMM},'{ORA,DIX},'{COP,IMM},'{ORA,SR},'{TSB,DP},'{ORA,DP},'{ASL,DP},'{ORA,DIL},
		'{PHP,IMP},'{ORA,IMM},'{ASL,IMP},'{PHD,IMP},'{TSB,ABS},'{ORA,ABS},'{ASL,ABS},'{ORA,ABL},
		'{BPL,REL},'{ORA,DIY},'{ORA,DIN},'{ORA,SRY},'{TRB,DP},'{ORA,DPX},'{ASL,DPX},'{ORA,DLY},
		'{CLC,IMP},'{ORA,ABY},'{INC,IMP},'{TCS,IMP},'{TRB,ABS},'{ORA,ABX},'{ASL,ABX},'{ORA,ALX},
		'{JSR,ABS},'{AND,DIX},'{JSL,ABL},'{AND,SR},'{BIT,DP},'{AND,DP},'{ROL,DP},'{AND,DIL},
		'{PLP,IMP},'{AND,IMM},'{ROL,IMP},'{PLD,IMP},'{BIT,ABS},'{AND,ABS},'{ROL,ABS},'{AND,ABL},
		'{BMI,REL},'{AND,DIY},'{AND,DIN},'{AND,SRY},'{BIT,DPX},'{AND,DPX},'{ROL,DPX},'{AND,DLY},
		'{SEC,IMP},'{AND,ABY},'{DEC,IMP},'{TSC,IMP},'{BIT,ABX},'{AND,ABX},'{ROL,ABX},'{AND,ALX},
		'{RTI,IMP},'{EOR,DIX},'{WDM,IMM},'{EOR,SR},'{MVP,MOV},'{EOR,DP},'{LSR,DP},'{EOR,DIL},
		'{PHA,IMP},'{EOR,IMM},'{LSR,IMP},'{PHK,IMP},'{JMP,ABS},'{EOR,ABS},'{LSR,ABS},'{EOR,ABL},
		'{BVC,REL},'{EOR,DIY},'{EOR,DIN},'{EOR,SRY},'{MVN,MOV},'{EOR,DPX},'{LSR,DPX},'{EOR,DLY},
		'{CLI,IMP},'{EOR,ABY},'{PHY,IMP},'{TCD,IMP},'{JML,ABL},'{EOR,ABX},'{LSR,ABX},'{EOR,ALX},
		'{RTS,IMP},'{ADC,DIX},'{PER,RLL},'{ADC,SR},'{STZ,DP},'{ADC,DP},'{ROR,DP},'{ADC,DIL},
		'{PLA,IMP},'{ADC,IMM},'{ROR,IMP},'{RTL,IMP},'{JMP,AIN},'{ADC,ABS},'{ROR,ABS},'{ADC,ABL},
		'{BVS,REL},'{ADC,DIY},'{ADC,DIN},'{ADC,SRY},'{STZ,DPX},'{ADC,DPX},'{ROR,DPX},'{ADC,DLY},
		'{SEI,IMP},'{ADC,ABY},'{PLY,IMP},'{TDC,IMP},'{JMP,AIX},'{ADC,ABX},'{ROR,ABX},'{ADC,ALX},
		'{BRA,REL},'{STA,DIX},'{BRL,RLL},'{STA,SR},'{STY,DP},'{STA,DP},'{STX,DP},'{STA,DIL},
		'{DEY,IMP},'{BIT,IMM},'{TXA,IMP},'{PHB,IMP},'{STY,ABS},'{STA,ABS},'{STX,ABS},'{STA,ABL},
		'{BCC,REL},'{STA,DIY},'{STA,DIN},'{STA,SRY},'{STY,DPX},'{STA,DPX},'{STX,DPY},'{STA,DLY},
		'{TYA,IMP},'{STA,ABY},'{TXS,IMP},'{TXY,IMP},'{STZ,ABS},'{STA,ABX},'{STZ,ABX},'{STA,ALX},
		'{LDY,IMM},'{LDA,DIX},'{LDX,IMM},'{LDA,SR},'{LDY,DP},'{LDA,DP},'{LDX,DP},'{LDA,DIL},
		'{TAY,IMP},'{LDA,IMM},'{TAX,IMP},'{PLB,IMP},'{LDY,ABS},'{LDA,ABS},'{LDX,ABS},'{LDA,ABL},
		'{BCS,REL},'{LDA,DIY},'{LDA,DIN},'{LDA,SRY},'{LDY,DPX},'{LDA,DPX},'{LDX,DPY},'{LDA,DLY},
		'{CLV,IMP},'{LDA,ABY},'{TSX,IMP},'{TYX,IMP},'{LDY,ABX},'{LDA,ABX},'{LDX,ABY},'{LDA,ALX},
		'{CPY,IMM},'{CMP,DIX},'{REP,IMM},'{CMP,SR},'{CPY,DP},'{CMP,DP},'{DEC,DP},'{CMP,DIL},
		'{INY,IMP},'{CMP,IMM},'{DEX,IMP},'{WAI,IMP},'{CPY,ABS},'{CMP,ABS},'{DEC,ABS},'{CMP,ABL},
		'{BNE,REL},'{CMP,DIY},'{CMP,DIN},'{CMP,SRY},'{PEI,DIN},'{CMP,DPX},'{DEC,DPX},'{CMP,DLY},
		'{CLD,IMP},'{CMP,ABY},'{PHX,IMP},'{STP,IMP},'{JMP,AIL},'{CMP,ABX},'{DEC,ABX},'{CMP,ALX},
		'{CPX,IMM},'{SBC,DIX},'{SEP,IMM},'{SBC,SR},'{CPX,DP},'{SBC,DP},'{INC,DP},'{SBC,DIL},
		'{INX,IMP},'{SBC,IMM},'{NOP,IMP},'{XBA,IMP},'{CPX,ABS},'{SBC,ABS},'{INC,ABS},'{SBC,ABL},
		'{BEQ,REL},'{SBC,DIY},'{SBC,DIN},'{SBC,SRY},'{PEA,ABS},'{SBC,DPX},'{INC,DPX},'{SBC,DLY},
		'{SED,IMP},'{SBC,ABY},'{PLX,IMP},'{XCE,IMP},'{JSR,AIX},'{SBC,ABX},'{INC,ABX},'{SBC,ALX}
	};

	// Operand bytes per mode, immediate counted as one
	function automatic logic [1:0] mode_bytes(amode_t md);
		logic [1:0] nb;
		unique case (md)
			IMP:                          nb = 2'd0;
			MOV, ABS, RLL, ABY, ABX,
			AIX, AIN, AIL:                nb = 2'd2;
			ABL, ALX:                     nb = 2'd3;
			SR, SRY, DIX, DP, IMM, REL,
			DIN, DIY, DIL, DLY, DPX, DPY: nb = 2'd1;
			default:                      nb = 2'd0;
		endcase
		return nb;
	endfunction

endpackage

[src/w816dec_operand.sv]
// ----------------------------------------------------------------------------
// w816dec_operand
// Length, operand value, branch target and block-end flag for one decoded
// opcode entry.
// ----------------------------------------------------------------------------
module w816dec_operand
	import w816dec_pkg::*;
(
	input  op_entry_t   entry,
	input  logic [7:0]  operand_one,
	input  logic [7:0]  operand_two,
	input  logic [7:0]  operand_three,
	input  logic [23:0] instr_address,
	input  logic [8:0]  status_bits,
	output dec_result_t result
);

	logic        mop;
	logic        xop;
	logic [1:0]  nb;
	logic [15:0] addend;
	logic [15:0] bias;
	logic [15:0] target;

	// Immediate width from M/X and E
	always_comb begin
		mop = (entry.mn == ORA) || (entry.mn == AND) || (entry.mn == EOR) ||
		      (entry.mn == ADC) || (entry.mn == BIT) || (entry.mn == LDA) ||
		      (entry.mn == CMP) || (entry.mn == SBC);
		xop = (entry.mn == LDY) || (entry.mn == LDX) || (entry.mn == CPY) ||
		      (entry.mn == CPX);
		nb  = mode_bytes(entry.md);
		if (entry.md == IMM &&
		    ((mop && (status_bits & ST_M_E_MASK) == 9'd0) ||
		     (xop && (status_bits & ST_X_E_MASK) == 9'd0)))
			nb = 2'd2;
	end

	// Relative target: 16-bit sum of address, offset and bias, bank kept
	always_comb begin
		if (entry.md == REL) begin
			addend = {{8{operand_one[7]}}, operand_one};
			bias   = REL_BIAS;
		end else begin
			addend = {operand_two, operand_one};
			bias   = RLL_BIAS;
		end
		target = instr_address[15:0] + addend + bias;
	end

	// Length, block-end flag and operand value
	always_comb begin
		result.mn   = entry.mn;
		result.md   = entry.md;
		result.len  = {1'b0, nb} + 3'd1;
		result.ends = (entry.mn == RTI) || (entry.mn == RTS) || (entry.mn == RTL) ||
		              (entry.mn == WAI) || (entry.mn == STP) || (entry.md == AIX) ||
		              (entry.md == AIN) || (entry.md == AIL);
		if (entry.md == REL || entry.md == RLL) begin
			result.value = {instr_address[23:16], target};
		end else begin
			unique case (nb)
				2'd0: result.value = 24'd0;
				2'd1: result.value = {16'd0, operand_one};
				2'd2: result.value = {8'd0, operand_two, operand_one};
				2'd3: result.value = {operand_three, operand_two, operand_one};
				default: result.value = 24'd0;
			endcase
		end
	end

endmodule

[src/sixteen_bit_6502_opcode_decoder_top.sv]
// Input word goes through the opcode ROM read and the operand stage to the output word.
// One word per cycle unless the output stalls; the synchronous ROM reads on advance.
// A stalled output holds the whole two-stage pipe; input ready follows output space.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// sixteen_bit_6502_opcode_decoder_top
// 65816 instruction decoder: opcode ROM lookup followed by operand assembly
// and branch target calculation, on a streaming interface.
// ----------------------------------------------------------------------------
module sixteen_bit_6502_opcode_decoder_top
	import w816dec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] opcode_byte, [15:8] operand_one, [23:16] operand_two,
	// [31:24] operand_three, [55:32] instr_address, [64:56] status_bits, rest zero
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [6:0] mnemonic_index, [11:7] address_mode, [14:12] instr_length,
	// [38:15] operand_value, [39] zero
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast       // ends_block
);

	logic        advance;
	logic        vld_s1;
	logic        vld_s2;
	op_entry_t   entry_s1;
	logic [23:0] bytes_s1;
	logic [23:0] addr_s1;
	logic [8:0]  status_s1;
	dec_result_t result;
	dec_result_t result_s2;

	// Pipe moves whenever the output register is free or being taken
	assign advance       = !vld_s2 || m_axis_tready;
	assign s_axis_tready = advance;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	// Opcode ROM, registered read, plus operand bytes alongside
	always_ff @(posedge clk) begin
		if (advance) begin
			entry_s1  <= OPTAB[s_axis_tdata[7:0]];
			bytes_s1  <= s_axis_tdata[31:8];
			addr_s1   <= s_axis_tdata[55:32];
			status_s1 <= s_axis_tdata[64:56];
		end
	end

	w816dec_operand u_operand (
		.entry         (entry_s1),
		.operand_one   (bytes_s1[7:0]),
		.operand_two   (bytes_s1[15:8]),
		.operand_three (bytes_s1[23:16]),
		.instr_address (addr_s1),
		.status_bits   (status_s1),
		.result        (result)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result;
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {1'b0, result_s2.value, result_s2.len,
	                        result_s2.md, result_s2.mn};
	assign m_axis_tlast  = result_s2.ends;

endmodule

[src/w816dec_checker.sv]
// ----------------------------------------------------------------------------
// w816dec_checker
// Port-level checks on the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module w816dec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic [2:0] out_len;
	logic       out_ends;

	// Length field and block-end flag of the offered word
	assign out_len  = m_axis_tdata[14:12];
	assign out_ends = m_axis_tvalid && m_axis_tlast;

	// A stalled word stays offered
	`ASSERT_CLK(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped")

	// Input is refused only while the output word is stalled
	`ASSERT_CLK(a_ready, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "needless input stall")

	// Length is one to four bytes
	`ASSERT_NEVER(a_len, m_axis_tvalid && (out_len == 3'd0 || out_len > 3'd4), "bad length")

	// Block-ending instructions are implied or absolute indirect
	`ASSERT_CLK(a_ends, out_ends |-> out_len == 3'd1 || out_len == 3'd3, "bad block end length")

endmodule

bind sixteen_bit_6502_opcode_decoder_top w816dec_checker u_w816dec_checker (.*);
